/* design/tomasulo_reservation_station_unit_defines.svh */
// ----------------------------------------------------------------------------
// Reservation station assertion macros
// Shared property forms for the reservation station checks.
// ----------------------------------------------------------------------------
`ifndef TOMASULO_RESERVATION_STATION_UNIT_DEFINES_SVH
`define TOMASULO_RESERVATION_STATION_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TRS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reservation station check failed");

// antecedent implies consequent in the next cycle
`define TRS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reservation station check failed");

`endif

/* design/trs_pkg.sv */
// ----------------------------------------------------------------------------
// Reservation station package
// Types, constants and tag helpers shared by the reservation station.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

  localparam int ENTRIES   = 2;
  localparam int FIRST_TAG = 4;
  localparam int TAG_W     = 3;
  localparam int OP_W      = 4;
  localparam int VAL_W     = 32;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [OP_W-1:0]  iop_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ISSUE    = 2'd1,
    CMD_CAPTURE  = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_op_t;

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_WAIT    = 3'd1,
    ST_READY   = 3'd2,
    ST_DISP    = 3'd3,
    ST_RETIRED = 3'd4
  } ent_state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    iop_t                    instr_op;
    tag_t                    src_a_tag;
    logic signed [VAL_W-1:0] src_a_value;
    tag_t                    src_b_tag;
    logic signed [VAL_W-1:0] src_b_value;
    tag_t                    bcast_tag;
    logic signed [VAL_W-1:0] bcast_value;
  } cmd_item_t;

  typedef struct packed {
    tag_t                    issued_tag;
    logic                    has_free;
    logic                    dispatch_valid;
    iop_t                    out_instr_op;
    logic signed [VAL_W-1:0] out_a_value;
    logic signed [VAL_W-1:0] out_b_value;
    tag_t                    out_dest_tag;
  } res_item_t;

  typedef struct packed {
    logic tick;
    logic load;
    logic capture;
    logic take;
  } ent_ctrl_t;

  typedef struct packed {
    ent_state_t              state;
    ent_state_t              state_next;
    iop_t                    op;
    logic signed [VAL_W-1:0] a_value;
    logic signed [VAL_W-1:0] b_value;
  } ent_stat_t;

  function automatic tag_t own_tag(input int idx);
    return tag_t'((FIRST_TAG + idx) % 8);
  endfunction

endpackage

`default_nettype wire

/* design/trs_entry.sv */
// ----------------------------------------------------------------------------
// Reservation station entry
// State, operation and source operands of one entry, with tick, issue,
// capture and dispatch updates.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_entry (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire trs_pkg::tag_t     own_tag,
  input  wire trs_pkg::ent_ctrl_t ctrl,
  input  wire trs_pkg::cmd_item_t item,
  output trs_pkg::ent_stat_t     stat
);

  import trs_pkg::*;

  ent_state_t              state, state_next;
  iop_t                    op, op_next;
  tag_t                    a_tag, a_tag_next;
  tag_t                    b_tag, b_tag_next;
  logic signed [VAL_W-1:0] a_value, a_value_next;
  logic signed [VAL_W-1:0] b_value, b_value_next;

  always_comb begin
    state_next   = state;
    op_next      = op;
    a_tag_next   = a_tag;
    b_tag_next   = b_tag;
    a_value_next = a_value;
    b_value_next = b_value;
    if (ctrl.tick) begin
      if (state == ST_WAIT && a_tag == '0 && b_tag == '0) begin
        state_next = ST_READY;
      end else if (state == ST_RETIRED) begin
        state_next = ST_EMPTY;
      end
    end
    if (ctrl.load) begin
      state_next   = ST_WAIT;
      op_next      = item.instr_op;
      a_tag_next   = item.src_a_tag;
      a_value_next = item.src_a_value;
      b_tag_next   = item.src_b_tag;
      b_value_next = item.src_b_value;
    end
    if (ctrl.capture) begin
      if (own_tag == item.bcast_tag) begin
        state_next = ST_RETIRED;
      end
      if (a_tag == item.bcast_tag) begin
        a_tag_next   = '0;
        a_value_next = item.bcast_value;
      end
      if (b_tag == item.bcast_tag) begin
        b_tag_next   = '0;
        b_value_next = item.bcast_value;
      end
    end
    if (ctrl.take) begin
      state_next = ST_DISP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_EMPTY;
      a_tag <= '0;
      b_tag <= '0;
    end else begin
      state <= state_next;
      a_tag <= a_tag_next;
      b_tag <= b_tag_next;
    end
  end

  always_ff @(posedge clk) begin
    op      <= op_next;
    a_value <= a_value_next;
    b_value <= b_value_next;
  end

  assign stat.state      = state;
  assign stat.state_next = state_next;
  assign stat.op         = op;
  assign stat.a_value    = a_value;
  assign stat.b_value    = b_value;

endmodule

`default_nettype wire

/* design/trs_pick.sv */
// ----------------------------------------------------------------------------
// Reservation station lowest-entry picker
// One-hot grant of the lowest requesting entry.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_pick (
  input  wire logic [trs_pkg::ENTRIES-1:0] req,
  output logic [trs_pkg::ENTRIES-1:0]      grant,
  output logic                             found
);

  import trs_pkg::*;

  logic [ENTRIES:0] taken;

  always_comb begin
    taken[0] = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      grant[i]   = req[i] & ~taken[i];
      taken[i+1] = taken[i] | req[i];
    end
  end

  assign found = taken[ENTRIES];

endmodule

`default_nettype wire

/* design/tomasulo_reservation_station_unit.sv */
// ----------------------------------------------------------------------------
// Tomasulo reservation station
// Command channel in (cmd), one result per command out (res). A command
// transfer lands in an input register; the next cycle the entries are
// updated and the result register is loaded, provided the result register
// is empty or its result transfers in that cycle. One command per cycle
// is sustained while res_stall is low, as a single update pass covers
// all entries.
// Commands: tick, issue to lowest empty entry, capture broadcast (tag 0
// ignored), dispatch of lowest ready entry. Every result carries has_free
// for the state after that command.
// Reset empties all entries and clears the valid flags of both registers. When res_stall is
// held, the result stays in place, one more command waits in the input
// register, and cmd_stall then rises until the result transfers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tomasulo_reservation_station_unit_defines.svh"

module tomasulo_reservation_station_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_stall,
  input  wire trs_pkg::cmd_item_t cmd,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output trs_pkg::res_item_t      res
);

  import trs_pkg::*;

  cmd_item_t  cmd_q;
  logic       cmd_q_valid;
  logic       proc;
  logic       cmd_take;
  res_item_t  res_next;

  logic       do_tick, do_issue, do_capture, do_dispatch;

  ent_ctrl_t  ctrl [ENTRIES];
  ent_stat_t  stat [ENTRIES];
  logic [ENTRIES-1:0] empty_req, ready_req, empty_grant, ready_grant, free_next;
  logic       empty_found, ready_found;

  assign cmd_stall = cmd_q_valid & res_valid & res_stall;
  assign cmd_take  = cmd_valid & ~cmd_stall;
  assign proc      = cmd_q_valid & ~(res_valid & res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_q_valid <= 1'b0;
    end else begin
      cmd_q_valid <= cmd_take | (cmd_q_valid & ~proc);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_q <= cmd;
    end
  end

  always_comb begin
    do_tick     = 1'b0;
    do_issue    = 1'b0;
    do_capture  = 1'b0;
    do_dispatch = 1'b0;
    unique case (cmd_op_t'(cmd_q.opcode))
      CMD_TICK:     do_tick     = proc;
      CMD_ISSUE:    do_issue    = proc;
      CMD_CAPTURE:  do_capture  = proc & (cmd_q.bcast_tag != '0);
      CMD_DISPATCH: do_dispatch = proc;
      default:      do_tick     = 1'b0;
    endcase
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_ent
    assign empty_req[g] = (stat[g].state == ST_EMPTY);
    assign ready_req[g] = (stat[g].state == ST_READY);
    assign free_next[g] = (stat[g].state_next == ST_EMPTY);

    assign ctrl[g].tick    = do_tick;
    assign ctrl[g].load    = do_issue & empty_grant[g];
    assign ctrl[g].capture = do_capture;
    assign ctrl[g].take    = do_dispatch & ready_grant[g];

    trs_entry u_entry (
      .clk     (clk),
      .rst     (rst),
      .own_tag (own_tag(g)),
      .ctrl    (ctrl[g]),
      .item    (cmd_q),
      .stat    (stat[g])
    );
  end

  trs_pick u_pick_empty (
    .req   (empty_req),
    .grant (empty_grant),
    .found (empty_found)
  );

  trs_pick u_pick_ready (
    .req   (ready_req),
    .grant (ready_grant),
    .found (ready_found)
  );

  always_comb begin
    res_next                = '0;
    res_next.has_free       = |free_next;
    res_next.dispatch_valid = do_dispatch & ready_found;
    for (int i = 0; i < ENTRIES; i++) begin
      if (do_issue & empty_grant[i]) begin
        res_next.issued_tag = res_next.issued_tag | own_tag(i);
      end
      if (do_dispatch & ready_grant[i]) begin
        res_next.out_instr_op = res_next.out_instr_op | stat[i].op;
        res_next.out_a_value  = res_next.out_a_value | stat[i].a_value;
        res_next.out_b_value  = res_next.out_b_value | stat[i].b_value;
        res_next.out_dest_tag = res_next.out_dest_tag | own_tag(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      res <= res_next;
    end
  end

  `TRS_ASSERT_SAME(a_stall_cause, clk, rst, cmd_stall, cmd_q_valid && res_valid && res_stall)
  `TRS_ASSERT_NEXT(a_proc_result, clk, rst, proc, res_valid)
  `TRS_ASSERT_SAME(a_issue_xor_disp, clk, rst, res_valid,
                   !(res.dispatch_valid && res.issued_tag != '0))
  `TRS_ASSERT_SAME(a_one_load, clk, rst, do_issue, $onehot0(empty_grant) && (empty_found || !(|empty_req)))

endmodule

`default_nettype wire
